/* src/encoder_pid_wheel_controller_top_macros.svh */
// Assertion macros for the encoder PID wheel controller.
// No dependencies; included by files that carry concurrent checks.
`ifndef ENCODER_PID_WHEEL_CONTROLLER_TOP_MACROS_SVH
`define ENCODER_PID_WHEEL_CONTROLLER_TOP_MACROS_SVH
`ifndef SYNTHESIS
// Check on every clock edge outside reset
`define EPWC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check on every clock edge, reset included
`define EPWC_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define EPWC_ASSERT(lbl, prop, msg)
`define EPWC_ASSERT_RST(lbl, prop, msg)
`endif
`endif

/* src/epwc_pkg.sv */
// Package for the encoder PID wheel controller: widths, codes and
// saturation helpers. No dependencies.
package epwc_pkg;

  localparam int CNT_W    = 32;  // position counter width
  localparam int INT_W    = 64;  // error integral width
  localparam int ERR_W    = 32;  // reported error width
  localparam int GAIN_W   = 24;
  localparam int RATE_W   = 16;
  localparam int EL_W     = 20;  // elapsed microseconds
  localparam int DUTY_W   = 8;
  localparam int SUM_W    = 65;  // integral sum before clamping
  localparam int NUM_W    = 52;  // |delta error| * 1e6 fits here
  localparam int DIV_STEPS = NUM_W;
  localparam int DCNT_W   = $clog2(DIV_STEPS);
  localparam logic [DCNT_W-1:0] DIV_LAST = DCNT_W'(DIV_STEPS - 1);
  localparam logic [31:0] US_PER_S = 32'd1000000;

  // Item kinds on the input tuser
  typedef enum logic [1:0] {
    FUNC_EDGE = 2'd0,
    FUNC_STEP = 2'd1,
    FUNC_OFF  = 2'd2
  } func_t;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_GAIN_P = 3'd0,
    REG_GAIN_I = 3'd1,
    REG_GAIN_D = 3'd2,
    REG_RATE   = 3'd3,
    REG_INVERT = 3'd4
  } reg_idx_t;

  // Clamp a count difference to the signed error range
  function automatic logic signed [ERR_W-1:0] sat_err(input logic signed [CNT_W-1:0] d);
    logic signed [CNT_W+ERR_W-1:0] w;
    logic signed [CNT_W+ERR_W-1:0] hi;
    logic signed [CNT_W+ERR_W-1:0] lo;
    w  = (CNT_W+ERR_W)'(d);
    hi = $signed({{(CNT_W+1){1'b0}}, {(ERR_W-1){1'b1}}});
    lo = $signed({{(CNT_W+1){1'b1}}, {(ERR_W-1){1'b0}}});
    if (w > hi) begin
      return hi[ERR_W-1:0];
    end else if (w < lo) begin
      return lo[ERR_W-1:0];
    end
    return w[ERR_W-1:0];
  endfunction

  // Clamp a wide integral sum to the integral width
  function automatic logic signed [INT_W-1:0] sat_int(input logic signed [SUM_W-1:0] s);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = $signed({{(SUM_W-INT_W+1){1'b0}}, {(INT_W-1){1'b1}}});
    lo = $signed({{(SUM_W-INT_W+1){1'b1}}, {(INT_W-1){1'b0}}});
    if (s > hi) begin
      return hi[INT_W-1:0];
    end else if (s < lo) begin
      return lo[INT_W-1:0];
    end
    return s[INT_W-1:0];
  endfunction

endpackage

/* src/encoder_pid_wheel_controller_top.sv */
// Encoder PID wheel controller: edge counter, PID sequencer, duty outputs.
// Depends on epwc_pkg and encoder_pid_wheel_controller_top_macros.svh.
//
// Usage:
//   Input stream s_*: s_tuser[1:0] is the item kind (0 encoder edge,
//   1 control step, 2 disable drives); s_tdata carries phase_b and
//   elapsed_us. Every request yields exactly one result on m_*, which
//   reports both duties, the last error and the zero elapsed time flag.
//   Configuration writes on cfg_* are always taken (cfg_ready is high).
// Sequencing:
//   Encoder edge, disable and unused kinds go from accept straight to the
//   done state. A control step with nonzero elapsed time runs the
//   52-step restoring divider for the derivative and five passes through
//   the one shared 32x32 multiplier. With zero elapsed time the divider
//   and two passes are skipped.
//   One request is in work at a time; s_tready is high only when idle.
// Reset: synchronous, clears position, target, errors, integral, duties
//   and gains. A stalled receiver holds the result in the output register;
//   the next finished request waits until that register frees up.
`include "encoder_pid_wheel_controller_top_macros.svh"

module encoder_pid_wheel_controller_top
  import epwc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // Input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // [0] phase_b, [20:1] elapsed_us, [23:21] zero
  input  logic [1:0]  s_tuser,   // [1:0] func
  // Result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // [7:0] drive_a, [15:8] drive_b,
                                 // [47:16] error, [48] zero_time, [55:49] zero
  // Configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_EI,    // error * elapsed, then integral update
    ST_DN,    // delta error * 1e6
    ST_DIV,   // divide by elapsed
    ST_TP,    // proportional term
    ST_TD,    // derivative term
    ST_TI,    // integral term
    ST_FIN,
    ST_DONE
  } state_t;

  state_t state;

  // Configuration registers
  logic signed [GAIN_W-1:0] gain_p, gain_i, gain_d;
  logic signed [RATE_W-1:0] target_rate;
  logic                     invert;

  // Controller state
  logic [CNT_W-1:0]         count, target;
  logic signed [ERR_W-1:0]  last_error, prev_error;
  logic signed [INT_W-1:0]  integral;
  logic [DUTY_W-1:0]        duty_a, duty_b;
  logic                     zero_time;

  // Sequencer counters
  logic [1:0]               mph;
  logic [DCNT_W-1:0]        div_cnt;

  // Datapath registers
  logic [EL_W-1:0]          el;
  logic [31:0]              diff_mag;
  logic                     diff_neg;
  logic [63:0]              mx;
  logic [31:0]              my;
  logic                     mneg;
  logic [63:0]              prod;
  logic [95:0]              acc;
  logic [NUM_W-1:0]         num;
  logic [EL_W-1:0]          rem;
  logic signed [63:0]       u;

  // Combinational helpers
  logic                     in_mul;
  logic [31:0]              mul_a;
  logic [63:0]              mul_p;
  logic [31:0]              e_mag;
  logic signed [ERR_W:0]    diff;
  logic [ERR_W:0]           diff_abs;
  logic [GAIN_W-1:0]        gp_abs, gi_abs, gd_abs;
  logic [INT_W-1:0]         i_abs;
  logic signed [SUM_W-1:0]  i_base, i_add, i_sum;
  logic [63:0]              term;
  logic signed [63:0]       u_sum, u_neg;
  logic [EL_W:0]            rem_sh;
  logic                     q_bit;
  logic signed [RATE_W:0]   rate_ext, rate_eff;

  assign s_tready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;

  // Shared multiplier: low half of the operand first, then high half
  assign in_mul = (state == ST_EI) || (state == ST_DN) || (state == ST_TP) ||
                  (state == ST_TD) || (state == ST_TI);
  assign mul_a  = mph[0] ? mx[63:32] : mx[31:0];
  assign mul_p  = 64'(mul_a) * 64'(my);

  // Magnitudes and signs of operands
  always_comb begin
    e_mag    = last_error[ERR_W-1] ? 32'(-last_error) : 32'(last_error);
    diff     = {last_error[ERR_W-1], last_error} - {prev_error[ERR_W-1], prev_error};
    diff_abs = diff[ERR_W] ? (ERR_W+1)'(-diff) : (ERR_W+1)'(diff);
    gp_abs   = gain_p[GAIN_W-1] ? GAIN_W'(-gain_p) : GAIN_W'(gain_p);
    gi_abs   = gain_i[GAIN_W-1] ? GAIN_W'(-gain_i) : GAIN_W'(gain_i);
    gd_abs   = gain_d[GAIN_W-1] ? GAIN_W'(-gain_d) : GAIN_W'(gain_d);
    i_abs    = integral[INT_W-1] ? INT_W'(-integral) : INT_W'(integral);
  end

  // Integral update: one add or subtract, then clamp
  always_comb begin
    i_base = SUM_W'(integral);
    i_add  = SUM_W'(acc[63:0]);
    i_sum  = mneg ? (i_base - i_add) : (i_base + i_add);
  end

  // Term scaling and accumulation into u
  always_comb begin
    case (state)
      ST_TP:   term = acc[8 +: 64];
      ST_TD:   term = acc[16 +: 64];
      default: term = acc[32 +: 64];
    endcase
    u_sum = mneg ? (u - $signed(term)) : (u + $signed(term));
    u_neg = -u;
  end

  // One restoring divide step
  always_comb begin
    rem_sh = {rem, num[NUM_W-1]};
    q_bit  = (rem_sh >= {1'b0, el});
  end

  // Target step, negated for a reversed wheel
  always_comb begin
    rate_ext = {target_rate[RATE_W-1], target_rate};
    rate_eff = invert ? (RATE_W+1)'(-rate_ext) : rate_ext;
  end

  // Sequencer, controller state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      m_tvalid    <= 1'b0;
      m_tdata     <= '0;
      gain_p      <= '0;
      gain_i      <= '0;
      gain_d      <= '0;
      target_rate <= '0;
      invert      <= 1'b0;
      count       <= '0;
      target      <= '0;
      last_error  <= '0;
      prev_error  <= '0;
      integral    <= '0;
      duty_a      <= '0;
      duty_b      <= '0;
      zero_time   <= 1'b0;
      mph         <= '0;
      div_cnt     <= '0;
    end else begin
      // Take configuration writes
      if (cfg_valid) begin
        case (cfg_index)
          REG_GAIN_P: gain_p      <= cfg_data;
          REG_GAIN_I: gain_i      <= cfg_data;
          REG_GAIN_D: gain_d      <= cfg_data;
          REG_RATE:   target_rate <= cfg_data[RATE_W-1:0];
          REG_INVERT: invert      <= cfg_data[0];
          default: ;
        endcase
      end

      // Drop the result once taken, unless the next one loads now
      if (m_tvalid && m_tready && state != ST_DONE) begin
        m_tvalid <= 1'b0;
      end

      // Advance the step counters
      mph     <= in_mul ? mph + 2'd1 : 2'd0;
      div_cnt <= (state == ST_DIV) ? div_cnt + DCNT_W'(1) : '0;

      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            zero_time <= 1'b0;
            state     <= ST_DONE;
            case (s_tuser)
              FUNC_EDGE: begin
                count <= s_tdata[0] ? count + CNT_W'(1) : count - CNT_W'(1);
              end
              FUNC_STEP: begin
                last_error <= sat_err($signed(count - target));
                zero_time  <= (s_tdata[EL_W:1] == '0);
                state      <= ST_PREP;
              end
              FUNC_OFF: begin
                duty_a <= '0;
                duty_b <= '0;
              end
              default: ;
            endcase
          end
        end
        ST_PREP: begin
          state <= (el != '0) ? ST_EI : ST_TP;
        end
        ST_EI: begin
          if (mph == 2'd3) begin
            integral <= sat_int(i_sum);
            state    <= ST_DN;
          end
        end
        ST_DN: begin
          if (mph == 2'd3) begin
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_cnt == DIV_LAST) begin
            state <= ST_TP;
          end
        end
        ST_TP: begin
          if (mph == 2'd3) begin
            state <= ST_TD;
          end
        end
        ST_TD: begin
          if (mph == 2'd3) begin
            state <= ST_TI;
          end
        end
        ST_TI: begin
          if (mph == 2'd3) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          // Pick the driven side; a zero control signal keeps the duties
          if (u > 0) begin
            duty_a <= (|u[62:8]) ? {DUTY_W{1'b1}} : u[DUTY_W-1:0];
            duty_b <= '0;
          end else if (u < 0) begin
            duty_a <= '0;
            duty_b <= (|u_neg[62:8]) ? {DUTY_W{1'b1}} : u_neg[DUTY_W-1:0];
          end
          prev_error <= last_error;
          target     <= target + CNT_W'(rate_eff);
          state      <= ST_DONE;
        end
        ST_DONE: begin
          // Hold until the result register is free
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {7'd0, zero_time, last_error, duty_b, duty_a};
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Datapath: operands, products, divider and control sum
  always_ff @(posedge clk) begin
    if (in_mul) begin
      prod <= mul_p;
      if (mph == 2'd1) begin
        acc <= {32'd0, prod};
      end else if (mph == 2'd2) begin
        acc <= acc + {prod, 32'd0};
      end
    end

    case (state)
      ST_IDLE: begin
        el <= s_tdata[EL_W:1];
        u  <= '0;
      end
      ST_PREP: begin
        diff_mag <= diff_abs[31:0];
        diff_neg <= diff[ERR_W];
        num      <= '0;
        mx       <= 64'(e_mag);
        if (el != '0) begin
          my   <= 32'(el);
          mneg <= last_error[ERR_W-1];
        end else begin
          my   <= 32'(gp_abs);
          mneg <= last_error[ERR_W-1] ^ gain_p[GAIN_W-1];
        end
      end
      ST_EI: begin
        if (mph == 2'd3) begin
          mx   <= 64'(diff_mag);
          my   <= US_PER_S;
          mneg <= diff_neg;
        end
      end
      ST_DN: begin
        if (mph == 2'd3) begin
          num <= acc[NUM_W-1:0];
          rem <= '0;
        end
      end
      ST_DIV: begin
        rem <= q_bit ? EL_W'(rem_sh - {1'b0, el}) : rem_sh[EL_W-1:0];
        num <= {num[NUM_W-2:0], q_bit};
        if (div_cnt == DIV_LAST) begin
          mx   <= 64'(e_mag);
          my   <= 32'(gp_abs);
          mneg <= last_error[ERR_W-1] ^ gain_p[GAIN_W-1];
        end
      end
      ST_TP: begin
        if (mph == 2'd3) begin
          u    <= u_sum;
          mx   <= 64'(num);
          my   <= 32'(gd_abs);
          mneg <= diff_neg ^ gain_d[GAIN_W-1];
        end
      end
      ST_TD: begin
        if (mph == 2'd3) begin
          u    <= u_sum;
          mx   <= 64'(i_abs);
          my   <= 32'(gi_abs);
          mneg <= integral[INT_W-1] ^ gain_i[GAIN_W-1];
        end
      end
      ST_TI: begin
        if (mph == 2'd3) begin
          u <= u_sum;
        end
      end
      default: ;
    endcase
  end

  // Checks
  `EPWC_ASSERT(a_busy_after_accept, (s_tvalid && s_tready) |=> !s_tready, "request taken while busy")
  `EPWC_ASSERT(a_one_side, !(duty_a != '0 && duty_b != '0), "both bridge sides driven")
  `EPWC_ASSERT(a_div_bound, (state == ST_DIV) |-> (div_cnt <= DIV_LAST), "divider overran")
  `EPWC_ASSERT(a_out_from_done, $rose(m_tvalid) |-> ($past(state) == ST_DONE), "result without request")
  `EPWC_ASSERT_RST(a_reset_idle, rst |=> (state == ST_IDLE && !m_tvalid), "reset left block busy")

endmodule
